// ----- design/mhfl_pkg.sv -----
// Shared constants, payload types and helper functions of the header field locator.
package mhfl_pkg;

  localparam int MAX_NAME_BYTES = 32;
  localparam int OFFSET_BITS    = 16;
  localparam int NAME_LEN_BITS  = 6;
  localparam int NAME_STORE     = 32;
  localparam int NAME_SEL_BITS  = 5;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_LENGTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_BYTES0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_BYTES1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_BYTES2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_BYTES3 = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] line_offset;
    logic [OFFSET_BITS-1:0] value_offset;
    logic [OFFSET_BITS-1:0] value_end_offset;
    logic [OFFSET_BITS-1:0] field_length;
  } out_item_t;

  // Header name as seen by the scanner: length already clamped.
  typedef struct packed {
    logic [NAME_LEN_BITS-1:0]     len;
    logic [NAME_STORE-1:0][7:0]   bytes;
  } name_cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

endpackage

// ----- design/mhfl_cfg_regs.sv -----
// Configuration registers holding the header name and its clamped length.
module mhfl_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mhfl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mhfl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output mhfl_pkg::name_cfg_t                 name_cfg
);
  import mhfl_pkg::*;

  logic [NAME_LEN_BITS-1:0]   len_r;
  logic [3:0][CFG_DATA_BITS-1:0] bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      bytes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NAME_LENGTH: len_r      <= cfg_data[NAME_LEN_BITS-1:0];
        CFG_NAME_BYTES0: bytes_r[0] <= cfg_data;
        CFG_NAME_BYTES1: bytes_r[1] <= cfg_data;
        CFG_NAME_BYTES2: bytes_r[2] <= cfg_data;
        CFG_NAME_BYTES3: bytes_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lengths beyond the name store are treated as the full store.
  assign name_cfg.len = (len_r > NAME_LEN_BITS'(MAX_NAME_BYTES)) ?
                        NAME_LEN_BITS'(MAX_NAME_BYTES) : len_r;
  assign name_cfg.bytes = bytes_r;

endmodule

// ----- design/mail_header_field_locator.sv -----
// A byte sits in input register in_r; its result is registered in out_r for out_valid.
// Throughput: one byte per cycle; a full, stalled result register holds back only a byte
// that itself produces a result, through the one-item input register.
// One result per message, when the search is decided or at the last byte.
// Reset (rst_n low at a clock edge) clears handshake state, scan state and the name registers.
module mail_header_field_locator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mhfl_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mhfl_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mhfl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mhfl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mhfl_pkg::*;

  typedef enum logic [2:0] {
    PH_MATCH, PH_BLANKS, PH_VALUE, PH_FOLD, PH_DONE
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  name_cfg_t name_cfg;

  mhfl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .name_cfg (name_cfg)
  );

  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r, out_nxt;

  phase_t                   phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0]   pos_r, pos_nxt;
  logic [NAME_LEN_BITS-1:0] idx_r, idx_nxt;
  logic                     ok_r, ok_nxt;
  logic [OFFSET_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0]   vstart_r, vstart_nxt;
  logic [OFFSET_BITS-1:0]   cand_r, cand_nxt;
  logic                     cr_r, cr_nxt;

  logic                     emit;
  logic                     hit;
  logic [OFFSET_BITS-1:0]   e_line, e_val, e_end;
  logic                     go_blanks, go_value;
  logic [7:0]               b;
  logic                     is_crlf;
  logic [NAME_LEN_BITS-1:0] idx_inc;
  logic                     proc;
  logic                     in_accept;

  assign b       = in_r.data_byte;
  assign is_crlf = (b == CH_CR) || (b == CH_LF);
  assign idx_inc = idx_r + NAME_LEN_BITS'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = (pos_r == OFF_MAX) ? pos_r : pos_r + OFFSET_BITS'(1);
    idx_nxt    = idx_r;
    ok_nxt     = ok_r;
    line_nxt   = line_r;
    vstart_nxt = vstart_r;
    cand_nxt   = cand_r;
    cr_nxt     = cr_r;
    emit       = 1'b0;
    hit        = 1'b0;
    e_line     = '0;
    e_val      = '0;
    e_end      = '0;
    go_blanks  = 1'b0;
    go_value   = 1'b0;

    unique case (phase_r)
      PH_MATCH: begin
        // A blank line after the first line closes the search unfound.
        if (ok_r && idx_r == '0 && line_r != '0 && is_crlf) begin
          emit      = 1'b1;
          phase_nxt = PH_DONE;
        end else if (ok_r && idx_r >= name_cfg.len) begin
          go_blanks = 1'b1;
        end else if (b == CH_LF) begin
          line_nxt = pos_nxt;
          idx_nxt  = '0;
          ok_nxt   = 1'b1;
        end else if (ok_r) begin
          if (fold_case(b) == fold_case(name_cfg.bytes[idx_r[NAME_SEL_BITS-1:0]])) begin
            idx_nxt = idx_inc;
            if (idx_inc >= name_cfg.len) phase_nxt = PH_BLANKS;
          end else begin
            ok_nxt = 1'b0;
          end
        end
      end
      PH_BLANKS: go_blanks = 1'b1;
      PH_VALUE:  go_value  = 1'b1;
      PH_FOLD: begin
        if (cr_r && b == CH_LF) begin
          cr_nxt = 1'b0;
        end else if (is_blank(b)) begin
          phase_nxt = PH_VALUE;
          cr_nxt    = 1'b0;
        end else begin
          emit      = 1'b1;
          hit       = 1'b1;
          e_line    = line_r;
          e_val     = vstart_r;
          e_end     = cand_r;
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (go_blanks) begin
      if (is_blank(b)) begin
        phase_nxt = PH_BLANKS;
      end else begin
        vstart_nxt = pos_r;
        phase_nxt  = PH_VALUE;
        go_value   = 1'b1;
      end
    end

    if (go_value && is_crlf) begin
      cand_nxt  = pos_r;
      cr_nxt    = (b == CH_CR);
      phase_nxt = PH_FOLD;
    end

    // The last byte closes whatever search is still open, then the scan restarts.
    if (in_r.last_byte) begin
      if (!emit) begin
        unique case (phase_nxt)
          PH_BLANKS: begin
            emit = 1'b1; hit = 1'b1;
            e_line = line_nxt; e_val = pos_nxt; e_end = pos_nxt;
          end
          PH_VALUE: begin
            emit = 1'b1; hit = 1'b1;
            e_line = line_nxt; e_val = vstart_nxt; e_end = pos_nxt;
          end
          PH_FOLD: begin
            emit = 1'b1; hit = 1'b1;
            e_line = line_nxt; e_val = vstart_nxt; e_end = cand_nxt;
          end
          PH_MATCH: emit = 1'b1;
          PH_DONE:  ;
          default:  ;
        endcase
      end
      phase_nxt  = PH_MATCH;
      pos_nxt    = '0;
      idx_nxt    = '0;
      ok_nxt     = 1'b1;
      line_nxt   = '0;
      vstart_nxt = '0;
      cand_nxt   = '0;
      cr_nxt     = 1'b0;
    end
  end

  always_comb begin
    out_nxt.found            = hit;
    out_nxt.line_offset      = e_line;
    out_nxt.value_offset     = e_val;
    out_nxt.value_end_offset = e_end;
    out_nxt.field_length     = e_end - e_line;
  end

  // An item that produces no result can move on even while the result register is stalled.
  assign proc      = in_vld_r && (!emit || !out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !proc;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) in_vld_nxt = 1'b1;
    else if (proc) in_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (proc && emit) out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_MATCH;
      pos_r     <= '0;
      idx_r     <= '0;
      ok_r      <= 1'b1;
      line_r    <= '0;
      vstart_r  <= '0;
      cand_r    <= '0;
      cr_r      <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (proc) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        idx_r    <= idx_nxt;
        ok_r     <= ok_nxt;
        line_r   <= line_nxt;
        vstart_r <= vstart_nxt;
        cand_r   <= cand_nxt;
        cr_r     <= cr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) in_r <= in_data;
    if (proc && emit) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.line_offset == '0 && out_data.value_offset == '0 &&
      out_data.value_end_offset == '0 && out_data.field_length == '0)
    else $error("unfound result carries nonzero offsets");

  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.value_offset >= out_data.line_offset &&
      out_data.value_end_offset >= out_data.value_offset)
    else $error("found result offsets out of order");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc |=> in_vld_r && $stable(in_r) && $stable(phase_r))
    else $error("held item or scan state lost while stalled");

endmodule
